// ===== design/m2h_pkg.sv =====
// Package for the MurmurHash2 byte stream hash: queue entry type, sequencer states
// and hash constants. Used by the top level, front end, queue and back end; no dependencies.
package m2h_pkg;

  localparam logic [31:0] MUR_MULT       = 32'h5bd1e995;
  localparam int          MUR_WORD_SHIFT = 24;
  localparam int          MUR_FIN_SHIFT_A = 13;
  localparam int          MUR_FIN_SHIFT_B = 15;

  localparam int OP_QUEUE_DEPTH = 4;

  // One queued operation for the mixing back end.
  typedef struct packed {
    logic        seed;     // load data as the new running hash
    logic        word;     // data is a complete little-endian word to fold in
    logic        fin;      // finalize and emit after the above
    logic        tail_en;  // one to three tail bytes are pending at finalize
    logic [31:0] data;     // seed length or packed word
    logic [23:0] tail;     // pending tail bytes, little-endian
  } op_t;

  // Queue status seen by both ends.
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_W_MUL1,
    ST_W_MUL2,
    ST_W_MUL3,
    ST_W_FOLD,
    ST_F_TAIL,
    ST_F_MUL,
    ST_F_OUT
  } mix_state_t;

endpackage

// ===== design/murmur2_byte_stream_hash.sv =====
// MurmurHash2 (32-bit) over a byte stream, one message byte per input transfer.
// Top level: front end, operation queue and mixing back end. Depends on m2h_pkg.
//
// Input channel in_*: one byte per transfer. in_tuser marks the first byte of a
// message, whose in_tdata also carries the total length that seeds the hash;
// in_tlast marks the final byte. An empty message is a single transfer with
// in_tuser and in_tlast set and a length of zero; its data byte is ignored.
// Output channel out_*: one 32-bit hash per message, after the last byte.
//
// Throughput: the front end takes one byte per cycle as long as the four-entry
// operation queue has room. Every fourth byte queues a word operation that the
// back end runs after the pop in four steps (three passes through its single
// multiply-by-constant unit, then the fold). It pops nothing new until it is
// back in idle, so on a long message the queue fills and in_tready drops.
// First and last bytes queue their own operations; finalizing runs the tail
// multiply if tail bytes are pending, the finalize multiply and the output step.
// A stalled receiver holds the result in the output register; the back end
// waits there, the queue fills and then in_tready drops.
// Reset clears the queue, the byte packer and the running hash.
module murmur2_byte_stream_hash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [7:0] data_byte, [39:8] message_length
  input  logic        in_tuser,   // [0] first_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [31:0] hash_value
);

  m2h_pkg::q_stat_t q_stat;
  m2h_pkg::op_t     push_op, pop_op;
  logic             push, pop;

  m2h_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .data_byte      (in_tdata[7:0]),
    .first_byte     (in_tuser),
    .last_byte      (in_tlast),
    .message_length (in_tdata[39:8]),
    .in_ready       (in_tready),
    .q_stat         (q_stat),
    .push           (push),
    .push_op        (push_op)
  );

  m2h_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .pop_op  (pop_op),
    .q_stat  (q_stat)
  );

  m2h_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .pop_op     (pop_op),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .hash_value (out_tdata)
  );

endmodule

// ===== design/m2h_front.sv =====
// Front end: accepts message bytes, packs them into little-endian words and
// queues seed, word and finalize operations. Depends on m2h_pkg.
module m2h_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [7:0]         data_byte,
  input  logic               first_byte,
  input  logic               last_byte,
  input  logic [31:0]        message_length,
  output logic               in_ready,
  input  m2h_pkg::q_stat_t   q_stat,
  output logic               push,
  output m2h_pkg::op_t       push_op
);

  logic [23:0] pend_word_r, pend_word_nxt;
  logic [1:0]  pend_cnt_r, pend_cnt_nxt;
  logic [23:0] eff_word, new_word;
  logic [1:0]  eff_cnt, new_cnt;
  logic        accept, absorb, word_done;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    // A first item drops whatever an unfinished message left behind.
    eff_word  = first_byte ? 24'd0 : pend_word_r;
    eff_cnt   = first_byte ? 2'd0 : pend_cnt_r;
    absorb    = !(first_byte && last_byte && (message_length == 32'd0));
    word_done = absorb && (eff_cnt == 2'd3);
    new_word  = eff_word;
    new_cnt   = eff_cnt;
    if (word_done) begin
      new_word = 24'd0;
      new_cnt  = 2'd0;
    end else if (absorb) begin
      new_word[{eff_cnt, 3'b000} +: 8] = data_byte;
      new_cnt = eff_cnt + 2'd1;
    end

    push_op.seed    = first_byte;
    push_op.word    = word_done;
    push_op.fin     = last_byte;
    push_op.tail_en = last_byte && (new_cnt != 2'd0);
    push_op.data    = first_byte ? message_length : {data_byte, eff_word};
    push_op.tail    = new_word;
    push = accept && (first_byte || word_done || last_byte);

    pend_word_nxt = pend_word_r;
    pend_cnt_nxt  = pend_cnt_r;
    if (accept) begin
      pend_word_nxt = last_byte ? 24'd0 : new_word;
      pend_cnt_nxt  = last_byte ? 2'd0 : new_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_word_r <= 24'd0;
      pend_cnt_r  <= 2'd0;
    end else begin
      pend_word_r <= pend_word_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
    end
  end

endmodule

// ===== design/m2h_queue.sv =====
// Short operation queue between the front end and the mixing back end.
// Depends on m2h_pkg.
module m2h_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  m2h_pkg::op_t       push_op,
  input  logic               pop,
  output m2h_pkg::op_t       pop_op,
  output m2h_pkg::q_stat_t   q_stat
);

  localparam int Depth = m2h_pkg::OP_QUEUE_DEPTH;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  m2h_pkg::op_t     slots_r [Depth];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  count_r, count_nxt;
  logic             do_push, do_pop;

  assign q_stat.empty = (count_r == CntW'(0));
  assign q_stat.full  = (count_r == CntW'(Depth));
  assign pop_op       = slots_r[rd_ptr_r];

  always_comb begin
    do_push    = push && !q_stat.full;
    do_pop     = pop && !q_stat.empty;
    wr_ptr_nxt = do_push ? ((wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + PtrW'(1))
                         : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ((rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + PtrW'(1))
                        : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== design/m2h_back.sv =====
// Back end: sequences the word mix, fold and finalize steps through one shared
// multiply-by-constant unit and holds the result register. Depends on m2h_pkg.
module m2h_back (
  input  logic               clk,
  input  logic               rst_n,
  input  m2h_pkg::q_stat_t   q_stat,
  input  m2h_pkg::op_t       pop_op,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        hash_value
);

  m2h_pkg::mix_state_t state_r, state_nxt;
  m2h_pkg::op_t        op_r, op_nxt;
  logic [31:0] hash_r, hash_nxt;
  logic [31:0] prod_r, prod_nxt;
  logic [31:0] key_r, key_nxt;
  logic [31:0] out_data_r, out_data_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] mul_a, fin_x;
  logic        prod_load, out_load;

  assign out_valid  = out_valid_r;
  assign hash_value = out_data_r;
  assign out_load   = (state_r == m2h_pkg::ST_F_OUT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      m2h_pkg::ST_IDLE: begin
        if (!q_stat.empty) begin
          if (pop_op.word) begin
            state_nxt = m2h_pkg::ST_W_MUL1;
          end else if (pop_op.fin) begin
            state_nxt = pop_op.tail_en ? m2h_pkg::ST_F_TAIL : m2h_pkg::ST_F_MUL;
          end
        end
      end
      m2h_pkg::ST_W_MUL1: state_nxt = m2h_pkg::ST_W_MUL2;
      m2h_pkg::ST_W_MUL2: state_nxt = m2h_pkg::ST_W_MUL3;
      m2h_pkg::ST_W_MUL3: state_nxt = m2h_pkg::ST_W_FOLD;
      m2h_pkg::ST_W_FOLD: begin
        if (op_r.fin) begin
          state_nxt = op_r.tail_en ? m2h_pkg::ST_F_TAIL : m2h_pkg::ST_F_MUL;
        end else begin
          state_nxt = m2h_pkg::ST_IDLE;
        end
      end
      m2h_pkg::ST_F_TAIL: state_nxt = m2h_pkg::ST_F_MUL;
      m2h_pkg::ST_F_MUL:  state_nxt = m2h_pkg::ST_F_OUT;
      m2h_pkg::ST_F_OUT:  state_nxt = out_load ? m2h_pkg::ST_IDLE : m2h_pkg::ST_F_OUT;
      default:            state_nxt = m2h_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop           = 1'b0;
    op_nxt        = op_r;
    hash_nxt      = hash_r;
    key_nxt       = key_r;
    mul_a         = 32'd0;
    prod_load     = 1'b0;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    fin_x         = op_r.tail_en ? prod_r : hash_r;
    unique case (state_r)
      m2h_pkg::ST_IDLE: begin
        if (!q_stat.empty) begin
          pop    = 1'b1;
          op_nxt = pop_op;
          if (pop_op.seed) begin
            hash_nxt = pop_op.data;
          end
        end
      end
      m2h_pkg::ST_W_MUL1: begin
        mul_a     = op_r.data;
        prod_load = 1'b1;
      end
      m2h_pkg::ST_W_MUL2: begin
        mul_a     = prod_r ^ (prod_r >> m2h_pkg::MUR_WORD_SHIFT);
        prod_load = 1'b1;
      end
      m2h_pkg::ST_W_MUL3: begin
        key_nxt   = prod_r;
        mul_a     = hash_r;
        prod_load = 1'b1;
      end
      m2h_pkg::ST_W_FOLD: begin
        hash_nxt = prod_r ^ key_r;
      end
      m2h_pkg::ST_F_TAIL: begin
        mul_a     = hash_r ^ {8'd0, op_r.tail};
        prod_load = 1'b1;
      end
      m2h_pkg::ST_F_MUL: begin
        mul_a     = fin_x ^ (fin_x >> m2h_pkg::MUR_FIN_SHIFT_A);
        prod_load = 1'b1;
      end
      m2h_pkg::ST_F_OUT: begin
        if (out_load) begin
          out_data_nxt  = prod_r ^ (prod_r >> m2h_pkg::MUR_FIN_SHIFT_B);
          out_valid_nxt = 1'b1;
          hash_nxt      = 32'd0;
        end
      end
      default: begin
      end
    endcase
    prod_nxt = prod_load ? 32'(mul_a * m2h_pkg::MUR_MULT) : prod_r;
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    prod_r     <= prod_nxt;
    key_r      <= key_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= m2h_pkg::ST_IDLE;
      hash_r      <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hash_r      <= hash_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== design/m2h_checker.sv =====
// Port-level checks for the byte stream hash, bound to the top level.
// Depends on murmur2_byte_stream_hash ports only.
module m2h_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // Reset leaves an empty queue and no pending result.
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> (in_tready && !out_tvalid))
    else $error("in_tready low or out_tvalid high after reset");

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed or dropped");

  // The queue only fills on accepted transfers, so ready cannot drop without one.
  a_ready_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tready && !in_tvalid) |=> in_tready)
    else $error("in_tready dropped without an input transfer");

endmodule

bind murmur2_byte_stream_hash m2h_checker u_m2h_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
